// File: rtl/s2c_pkg.sv
// Shared constants and helpers for the seconds-to-calendar converter.
// Used by s2c_datapath and seconds_to_calendar_datetime_top; no dependencies.
package s2c_pkg;

  // Register stages from input capture to the output register
  localparam int unsigned NumStages = 7;

  localparam int unsigned OffsetWidth = 5;
  localparam int unsigned SecsWidth   = 31;
  localparam int unsigned MonthWidth  = 4;
  localparam int unsigned DayWidth    = 5;
  localparam int unsigned YearWidth   = 12;
  localparam int unsigned HourWidth   = 5;
  localparam int unsigned MinWidth    = 6;
  localparam int unsigned SecWidth    = 6;

  // Seconds are biased by one day so the day split never sees a negative sum
  localparam logic [33:0] SecsPerDay  = 34'd86400;
  localparam logic [33:0] SecsPerHour = 34'd3600;

  // Reciprocals: floor(x/d) == (x*M) >> K over the value ranges in use
  localparam logic [25:0] RecipDay675 = 26'd50903317;  // x < 2^25, K = 35
  localparam logic [22:0] RecipCent   = 23'd7525747;   // /36525, x < 2^22, K = 38
  localparam logic [13:0] RecipHour   = 14'd9321;      // /225, x < 2^13, K = 21
  localparam logic [23:0] RecipMonth  = 24'd8772372;   // *10000/306001, K = 28
  localparam logic [10:0] RecipMin    = 11'd1093;      // /15, x < 2^10, K = 14

  // Julian-day method rebased on the day count q = days + 1
  localparam logic [21:0] CentBias   = 22'd943590;
  localparam logic [16:0] DayBias    = 17'd9558;
  localparam logic [11:0] YearBase   = 12'd1965;

  // floor(30.6001 * e)
  function automatic logic [8:0] month_start(input logic [3:0] e);
    logic [8:0] r;
    case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/s2c_datapath.sv
// Seven-stage arithmetic pipeline: seconds to date and time of day.
// Depends on s2c_pkg; stage loads are driven by the top-level flow control.
module s2c_datapath import s2c_pkg::*; (
  input  logic                   clk,
  input  logic [NumStages-1:0]   stage_en,
  input  logic [SecsWidth-1:0]   secs,
  input  logic [OffsetWidth-1:0] offset,
  output logic [MonthWidth-1:0]  month,
  output logic [DayWidth-1:0]    day_of_month,
  output logic [YearWidth-1:0]   year,
  output logic [HourWidth-1:0]   hour,
  output logic [MinWidth-1:0]    minute,
  output logic [SecWidth-1:0]    second
);

  // stage 1
  logic [31:0] u_r1;
  logic [33:0] sum_nxt;
  // stage 2
  logic [31:0] u_r2;
  logic [14:0] q_r2;
  logic [50:0] pq;
  // stage 3
  logic [14:0] q_r3;
  logic [16:0] rest_r3;
  logic [21:0] numc_r3;
  logic [31:0] rem_full;
  // stage 4
  logic [14:0] q_r4;
  logic [16:0] rest_r4;
  logic [6:0]  cq_r4;
  logic [4:0]  hour_r4;
  logic [44:0] pc;
  logic [26:0] ph;
  // stage 5
  logic [8:0]  bd_r5;
  logic [11:0] r2_r5;
  logic [6:0]  cq_r5;
  logic [4:0]  hour_r5;
  logic [17:0] pd;
  logic [16:0] bd_full;
  logic [16:0] r2_full;
  // stage 6
  logic [8:0]  bd_r6;
  logic [3:0]  e_r6;
  logic [11:0] r2_r6;
  logic [5:0]  min_r6;
  logic [6:0]  cq_r6;
  logic [4:0]  hour_r6;
  logic [32:0] pe;
  logic [20:0] pm;
  // stage 7 (output)
  logic [3:0]  month_r;
  logic [4:0]  dom_r;
  logic [11:0] year_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [8:0]  dom_full;
  logic [3:0]  month_nxt;
  logic [11:0] r2_sec;

  // Shift by the offset and bias by one day so the sum stays positive
  assign sum_nxt = $signed({3'b000, secs}) + $signed(offset) * $signed(SecsPerHour)
                 + $signed(SecsPerDay);

  assign pq       = u_r1[31:7] * RecipDay675;
  assign rem_full = u_r2 - 32'(32'(q_r2) * 32'(SecsPerDay));
  assign pc       = numc_r3 * RecipCent;
  assign ph       = rest_r3[16:4] * RecipHour;
  assign pd       = 18'(cq_r4) * 18'd1461;
  assign bd_full  = 17'(q_r4) + DayBias - 17'(pd[17:2]);
  assign r2_full  = rest_r4 - 17'(17'(hour_r4) * 17'(SecsPerHour));
  assign pe       = bd_r5 * RecipMonth;
  assign pm       = r2_r5[11:2] * RecipMin;

  always_comb begin
    dom_full = bd_r6 - month_start(e_r6);
    if (e_r6 > 4'd13) begin
      month_nxt = e_r6 - 4'd13;
    end else begin
      month_nxt = e_r6 - 4'd1;
    end
    r2_sec = r2_r6 - 12'(12'(min_r6) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      u_r1 <= sum_nxt[31:0];
    end
    if (stage_en[1]) begin
      u_r2 <= u_r1;
      q_r2 <= pq[49:35];
    end
    if (stage_en[2]) begin
      q_r3    <= q_r2;
      rest_r3 <= rem_full[16:0];
      numc_r3 <= 22'(22'(q_r2) * 22'd100) + CentBias;
    end
    if (stage_en[3]) begin
      q_r4    <= q_r3;
      rest_r4 <= rest_r3;
      cq_r4   <= pc[44:38];
      hour_r4 <= ph[25:21];
    end
    if (stage_en[4]) begin
      bd_r5   <= bd_full[8:0];
      r2_r5   <= r2_full[11:0];
      cq_r5   <= cq_r4;
      hour_r5 <= hour_r4;
    end
    if (stage_en[5]) begin
      bd_r6   <= bd_r5;
      e_r6    <= pe[31:28];
      r2_r6   <= r2_r5;
      min_r6  <= pm[19:14];
      cq_r6   <= cq_r5;
      hour_r6 <= hour_r5;
    end
    if (stage_en[6]) begin
      month_r <= month_nxt;
      dom_r   <= dom_full[4:0];
      // drop a year for months after February
      year_r  <= 12'(cq_r6) + YearBase - 12'(month_nxt > 4'd2);
      hour_r  <= hour_r6;
      min_r   <= min_r6;
      sec_r   <= r2_sec[5:0];
    end
  end

  assign month        = month_r;
  assign day_of_month = dom_r;
  assign year         = year_r;
  assign hour         = hour_r;
  assign minute       = min_r;
  assign second       = sec_r;

endmodule

// File: rtl/seconds_to_calendar_datetime_top.sv
// Top level of the seconds-to-calendar converter: flow control and offset register.
// Depends on s2c_pkg and s2c_datapath.
//
// Usage:
//   Each request on the in_ channel carries a seconds count since
//   1989-12-31 00:00:00. The block adds cfg_wr_data hours (signed, written
//   with cfg_wr_en while idle) and returns one request on the out_ channel
//   with month, day, year, hour, minute and second.
//   A request is taken at a clock edge with in_valid high and in_stall low.
//   Each request passes through seven register stages, from input capture
//   to the output register, before out_valid rises.
//   Throughput: one request per cycle while out_stall is low, set by the
//   seven-stage pipeline with at most two constant multipliers per stage.
//   While out_stall is high the output register holds its request; stages
//   behind it keep filling bubbles, and in_stall rises only when every
//   stage holds a request.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the offset
//   to zero hours.
module seconds_to_calendar_datetime_top import s2c_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [OffsetWidth-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SecsWidth-1:0]   in_epoch_seconds,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MonthWidth-1:0]  out_month,
  output logic [DayWidth-1:0]    out_day_of_month,
  output logic [YearWidth-1:0]   out_year,
  output logic [HourWidth-1:0]   out_hour,
  output logic [MinWidth-1:0]    out_minute,
  output logic [SecWidth-1:0]    out_second
);

  logic [OffsetWidth-1:0] offset_r;
  logic [NumStages-1:0]   valid_r;
  logic [NumStages-1:0]   valid_nxt;
  logic [NumStages-1:0]   stage_en;
  logic [NumStages:0]     ready;

  // A stage may load when it is empty or the stage after it moves on
  always_comb begin
    ready[NumStages] = !out_stall;
    for (int i = NumStages - 1; i >= 0; i--) begin
      ready[i] = !valid_r[i] || ready[i+1];
    end
    stage_en = ready[NumStages-1:0];
    for (int i = 0; i < NumStages; i++) begin
      if (i == 0) begin
        valid_nxt[i] = ready[i] ? in_valid : valid_r[i];
      end else begin
        valid_nxt[i] = ready[i] ? valid_r[i-1] : valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      offset_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
    end
  end

  s2c_datapath u_datapath (
    .clk          (clk),
    .stage_en     (stage_en),
    .secs         (in_epoch_seconds),
    .offset       (offset_r),
    .month        (out_month),
    .day_of_month (out_day_of_month),
    .year         (out_year),
    .hour         (out_hour),
    .minute       (out_minute),
    .second       (out_second)
  );

  assign in_stall  = !ready[0];
  assign out_valid = valid_r[NumStages-1];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled while a pipeline stage is empty");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month != 5'd0))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("time of day out of range");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

endmodule
